>>> src/dmc_pkg.sv
// ----------------------------------------------------------------------------
// Diagonal Mahalanobis classifier package
// Shared constants and types for the classifier block.
// ----------------------------------------------------------------------------
package dmc_pkg;

  localparam int unsigned NumClasses  = 5;
  localparam int unsigned NumFeatures = 4;
  localparam int unsigned ClassW      = 3;
  localparam int unsigned FeatW       = 2;
  localparam int unsigned DataW       = 32;
  localparam int unsigned SqW         = 64;
  localparam int unsigned QCntW       = 7;
  localparam logic [DataW-1:0] ThreshReset = 32'd870102;
  localparam logic [DataW-1:0] Sat32       = 32'hFFFF_FFFF;

  localparam int unsigned InDataW  = 197;
  localparam int unsigned InTdataW = 200;
  localparam int unsigned OutTdataW = 40;

  typedef enum logic {
    REQ_LOAD     = 1'b0,
    REQ_CLASSIFY = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_MERGE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic [FeatW-1:0] feat;
  } lane_ctl_t;

endpackage

>>> src/dmc_lane.sv
// ----------------------------------------------------------------------------
// Classifier lane
// Accumulates one class distance: for each feature it squares the difference,
// divides by the variance bit-serially and adds the saturated quotient.
// ----------------------------------------------------------------------------
module dmc_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dmc_pkg::lane_ctl_t          ctl_i,
  input  logic [dmc_pkg::DataW-1:0]   x_i,
  input  logic [dmc_pkg::DataW-1:0]   mean_i,
  input  logic [dmc_pkg::DataW-1:0]   var_i,
  output logic                        busy_o,
  output logic [dmc_pkg::DataW-1:0]   sum_o
);

  logic [dmc_pkg::SqW-1:0]    num_q, num_d;
  logic [dmc_pkg::DataW:0]    rem_q, rem_d;
  logic [dmc_pkg::DataW-1:0]  var_q, var_d;
  logic [dmc_pkg::QCntW-1:0]  cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       ovf_q, ovf_d;
  logic [dmc_pkg::DataW+1:0]  acc_q, acc_d;
  logic [dmc_pkg::DataW:0]    diff;
  logic [dmc_pkg::DataW-1:0]  mag;
  logic [dmc_pkg::DataW:0]    trial;
  logic [dmc_pkg::DataW:0]    shifted;
  logic [dmc_pkg::DataW-1:0]  term;

  assign diff = {x_i[dmc_pkg::DataW-1], x_i} - {mean_i[dmc_pkg::DataW-1], mean_i};
  assign mag  = diff[dmc_pkg::DataW] ? dmc_pkg::DataW'(-diff) : diff[dmc_pkg::DataW-1:0];
  assign shifted = {rem_q[dmc_pkg::DataW-1:0], num_q[dmc_pkg::SqW-1]};
  assign trial   = shifted - {1'b0, var_q};

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    var_d  = var_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    ovf_d  = ovf_q;
    acc_d  = acc_q;
    term   = '0;
    if (ctl_i.start) begin
      num_d  = 64'(mag) * 64'(mag);
      rem_d  = '0;
      var_d  = var_i;
      cnt_d  = '0;
      busy_d = 1'b1;
      ovf_d  = (var_i == '0);
      if (ctl_i.feat == '0) begin
        acc_d = '0;
      end
    end else if (busy_q) begin
      num_d = {num_q[dmc_pkg::SqW-2:0], 1'b0};
      if (!trial[dmc_pkg::DataW]) begin
        rem_d    = trial;
        num_d[0] = 1'b1;
        if (cnt_q < dmc_pkg::QCntW'(dmc_pkg::DataW)) begin
          ovf_d = 1'b1;
        end
      end else begin
        rem_d = shifted;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == dmc_pkg::QCntW'(dmc_pkg::SqW - 1)) begin
        busy_d = 1'b0;
        term   = ovf_d ? dmc_pkg::Sat32 : num_d[dmc_pkg::DataW-1:0];
        acc_d  = acc_q + {2'b00, term};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    var_q <= var_d;
    ovf_q <= ovf_d;
    acc_q <= acc_d;
  end

  assign busy_o = busy_q;
  assign sum_o  = (acc_q[dmc_pkg::DataW+1:dmc_pkg::DataW] != 2'b00) ? dmc_pkg::Sat32
                                                                   : acc_q[dmc_pkg::DataW-1:0];

endmodule

>>> src/dmc_merge.sv
// ----------------------------------------------------------------------------
// Classifier merge stage
// Compares the class distances with the threshold and finds the minimum.
// ----------------------------------------------------------------------------
module dmc_merge (
  input  logic [dmc_pkg::NumClasses-1:0][dmc_pkg::DataW-1:0] sum_i,
  input  logic [dmc_pkg::DataW-1:0]                         thresh_i,
  output logic [4:0]                                        mask_o,
  output logic [dmc_pkg::DataW-1:0]                         min_o
);

  always_comb begin
    mask_o = '0;
    min_o  = dmc_pkg::Sat32;
    for (int c = 0; c < dmc_pkg::NumClasses; c++) begin
      if (c < 5 && sum_i[c] <= thresh_i) begin
        mask_o[c] = 1'b1;
      end
      if (sum_i[c] < min_o) begin
        min_o = sum_i[c];
      end
    end
  end

endmodule

>>> src/diagonal_mahalanobis_classifier_top.sv
// ----------------------------------------------------------------------------
// Diagonal Mahalanobis classifier
// Five class lanes accumulate feature distances; a merge stage reports matches.
// ----------------------------------------------------------------------------
// A classify transfer runs, for each feature in turn, a lane start, 64 restoring division
// steps and a completion check, then a merge, and a new input is taken from the cycle
// after the result transfer. The four features share one bit-serial divider in each class
// lane; one classify is in flight at a time. Reset clears control state and sets the
// threshold to 870102; tables are undefined.
module diagonal_mahalanobis_classifier_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: class_index, feature_index, model_mean, model_variance,
  //        perimeter_value, hu_first, hu_second, hu_third
  input  logic [dmc_pkg::InTdataW-1:0]   s_axis_tdata,
  // tuser: req_type
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: match_mask, any_match, min_distance
  output logic [dmc_pkg::OutTdataW-1:0]  m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dmc_pkg::DataW-1:0]      cfg_data_i
);

  localparam int unsigned Depth = dmc_pkg::NumClasses * dmc_pkg::NumFeatures;

  dmc_pkg::state_e state_q, state_d;
  logic [dmc_pkg::DataW-1:0] thresh_q;
  logic [dmc_pkg::DataW-1:0] mean_mem [Depth];
  logic [dmc_pkg::DataW-1:0] var_mem  [Depth];
  logic [dmc_pkg::NumClasses-1:0][dmc_pkg::DataW-1:0] mean_rd_q;
  logic [dmc_pkg::NumClasses-1:0][dmc_pkg::DataW-1:0] var_rd_q;
  logic [3:0][dmc_pkg::DataW-1:0] feat_q;
  logic [dmc_pkg::FeatW-1:0] fidx_q, fidx_d;
  logic                      start_q, start_d;
  logic [dmc_pkg::NumClasses-1:0] busy;
  logic [dmc_pkg::NumClasses-1:0][dmc_pkg::DataW-1:0] sums;
  logic [4:0]                mask, mask_q;
  logic [dmc_pkg::DataW-1:0] min_dist, min_q;
  logic                      in_fire;
  logic [dmc_pkg::ClassW-1:0] cls_in;
  logic [dmc_pkg::FeatW-1:0]  fi_in;
  dmc_pkg::lane_ctl_t         ctl;

  assign cls_in  = s_axis_tdata[2:0];
  assign fi_in   = s_axis_tdata[4:3];
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == dmc_pkg::ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= dmc_pkg::ThreshReset;
    end else if (cfg_valid_i) begin
      thresh_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && s_axis_tuser == dmc_pkg::REQ_LOAD
        && cls_in < dmc_pkg::ClassW'(dmc_pkg::NumClasses)) begin
      mean_mem[{cls_in, fi_in}] <= s_axis_tdata[36:5];
      var_mem[{cls_in, fi_in}]  <= s_axis_tdata[68:37];
    end
    for (int c = 0; c < dmc_pkg::NumClasses; c++) begin
      mean_rd_q[c] <= mean_mem[{dmc_pkg::ClassW'(c), fidx_d}];
      var_rd_q[c]  <= var_mem[{dmc_pkg::ClassW'(c), fidx_d}];
    end
    if (in_fire && s_axis_tuser == dmc_pkg::REQ_CLASSIFY) begin
      feat_q[0] <= s_axis_tdata[100:69];
      feat_q[1] <= s_axis_tdata[132:101];
      feat_q[2] <= s_axis_tdata[164:133];
      feat_q[3] <= s_axis_tdata[196:165];
    end
    if (state_q == dmc_pkg::ST_MERGE) begin
      mask_q <= mask;
      min_q  <= min_dist;
    end
  end

  always_comb begin
    state_d = state_q;
    fidx_d  = fidx_q;
    start_d = 1'b0;
    case (state_q)
      dmc_pkg::ST_IDLE: begin
        if (in_fire && s_axis_tuser == dmc_pkg::REQ_CLASSIFY) begin
          state_d = dmc_pkg::ST_RUN;
          fidx_d  = '0;
          start_d = 1'b1;
        end
      end
      dmc_pkg::ST_RUN: begin
        if (!start_q && busy == '0) begin
          if (fidx_q == dmc_pkg::FeatW'(dmc_pkg::NumFeatures - 1)) begin
            state_d = dmc_pkg::ST_MERGE;
          end else begin
            fidx_d  = fidx_q + 1'b1;
            start_d = 1'b1;
          end
        end
      end
      dmc_pkg::ST_MERGE: state_d = dmc_pkg::ST_OUT;
      dmc_pkg::ST_OUT: begin
        if (m_axis_tready) begin
          state_d = dmc_pkg::ST_IDLE;
        end
      end
      default: state_d = dmc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmc_pkg::ST_IDLE;
      fidx_q  <= '0;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fidx_q  <= fidx_d;
      start_q <= start_d;
    end
  end

  assign ctl.start = start_q;
  assign ctl.feat  = fidx_q;

  for (genvar c = 0; c < dmc_pkg::NumClasses; c++) begin : g_lane
    dmc_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .x_i    (feat_q[fidx_q]),
      .mean_i (mean_rd_q[c]),
      .var_i  (var_rd_q[c]),
      .busy_o (busy[c]),
      .sum_o  (sums[c])
    );
  end

  dmc_merge u_merge (
    .sum_i    (sums),
    .thresh_i (thresh_q),
    .mask_o   (mask),
    .min_o    (min_dist)
  );

  assign m_axis_tvalid = (state_q == dmc_pkg::ST_OUT);
  assign m_axis_tdata  = {2'b00, min_q, (mask_q != '0), mask_q};

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> state_q == dmc_pkg::ST_RUN) else $error("lane start outside run");
  a_lanes_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy != '0 |-> busy == '1) else $error("lanes out of step");
  a_any: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[5] == (m_axis_tdata[4:0] != '0)) else $error("any_match");
`endif

endmodule
